/* hw/rtl/tds_pkg.sv */
// Shared types and constants for the trajectory distance sum block.
`default_nettype none
package tds_pkg;

  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned TOTAL_W   = 63;
  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned DIMS_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STATUS_W  = 2;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

  localparam logic [DIMS_W-1:0] DIMS_PLANAR  = 2'd2;
  localparam logic [DIMS_W-1:0] DIMS_SPATIAL = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd2;

  typedef struct packed {
    logic occ;
    logic pair_ok;
    logic last;
  } tds_flags_t;

endpackage
`default_nettype wire

/* hw/rtl/trajectory_distance_sum_top.sv */
// Top level of the trajectory distance sum block.
// Takes one point pair per cycle while the pipe is not held. Each pair passes three front
// stages (absolute differences, squares, sum of squares), then a chain of COORD_WIDTH+1
// square root cells that settle one root bit each, then the run accumulator, whose result
// register takes the item when the last pair of a run arrives. The whole pipe holds while
// a result waits in the output register and the sink is not ready.
`default_nettype none
module trajectory_distance_sum_top #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // a_x, a_y, a_z, b_x, b_y, b_z
  input  wire logic [6*tds_pkg::FIELD_W-1:0]      s_axis_tdata_i,
  // pair_valid
  input  wire logic                               s_axis_tuser_i,
  input  wire logic                               s_axis_tlast_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // distance_total, zero pad
  output logic [tds_pkg::TOTAL_W:0]               m_axis_tdata_o,
  // pair_status
  output logic [tds_pkg::STATUS_W-1:0]            m_axis_tuser_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [tds_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  wire logic [tds_pkg::LIMIT_W-1:0]        cfg_data_i
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned FW    = tds_pkg::FIELD_W;
  localparam int unsigned NCELL = CW + 1;

  logic                          adv;
  logic                          out_valid;
  logic                          mode_q;
  logic [tds_pkg::DIMS_W-1:0]    dims_q;
  logic [tds_pkg::LIMIT_W-1:0]   limit_q;
  logic [tds_pkg::TOTAL_W-1:0]   total;
  tds_pkg::tds_flags_t           in_flags;

  logic [CW+2:0]        rem_w  [NCELL+1];
  logic [CW:0]          root_w [NCELL+1];
  logic [2*CW+1:0]      rad_w  [NCELL+1];
  logic [CW-1:0]        absx_w [NCELL+1];
  tds_pkg::tds_flags_t  flg_w  [NCELL+1];

  assign adv             = !out_valid || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign cfg_ready_o     = 1'b1;

  assign in_flags.occ     = s_axis_tvalid_i;
  assign in_flags.pair_ok = s_axis_tuser_i;
  assign in_flags.last    = s_axis_tlast_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b1;
      dims_q  <= tds_pkg::DIMS_PLANAR;
      limit_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        tds_pkg::CFG_MODE:  mode_q  <= cfg_data_i[0];
        tds_pkg::CFG_DIMS:  dims_q  <= cfg_data_i[tds_pkg::DIMS_W-1:0];
        tds_pkg::CFG_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tds_front #(.CW(CW)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .a_x_i   (s_axis_tdata_i[0*FW +: CW]),
    .a_y_i   (s_axis_tdata_i[1*FW +: CW]),
    .a_z_i   (s_axis_tdata_i[2*FW +: CW]),
    .b_x_i   (s_axis_tdata_i[3*FW +: CW]),
    .b_y_i   (s_axis_tdata_i[4*FW +: CW]),
    .b_z_i   (s_axis_tdata_i[5*FW +: CW]),
    .use_z_i (dims_q == tds_pkg::DIMS_SPATIAL),
    .flags_i (in_flags),
    .sum_o   (rad_w[0]),
    .absx_o  (absx_w[0]),
    .flags_o (flg_w[0])
  );

  assign rem_w[0]  = '0;
  assign root_w[0] = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    tds_cell #(.CW(CW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .rem_i   (rem_w[i]),
      .root_i  (root_w[i]),
      .rad_i   (rad_w[i]),
      .absx_i  (absx_w[i]),
      .flags_i (flg_w[i]),
      .rem_o   (rem_w[i+1]),
      .root_o  (root_w[i+1]),
      .rad_o   (rad_w[i+1]),
      .absx_o  (absx_w[i+1]),
      .flags_o (flg_w[i+1])
    );
  end

  tds_accum #(.CW(CW), .COUNT_WIDTH(COUNT_WIDTH)) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .root_i      (root_w[NCELL]),
    .absx_i      (absx_w[NCELL]),
    .flags_i     (flg_w[NCELL]),
    .mode_i      (mode_q),
    .dims_i      (dims_q),
    .limit_i     (limit_q),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (out_valid),
    .total_o     (total),
    .status_o    (m_axis_tuser_o)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = {1'b0, total};

endmodule
`default_nettype wire

/* hw/rtl/tds_front.sv */
// Front stages: absolute coordinate differences, squares and their sum.
`default_nettype none
module tds_front #(
  parameter int unsigned CW = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic [CW-1:0]          a_x_i,
  input  wire logic [CW-1:0]          a_y_i,
  input  wire logic [CW-1:0]          a_z_i,
  input  wire logic [CW-1:0]          b_x_i,
  input  wire logic [CW-1:0]          b_y_i,
  input  wire logic [CW-1:0]          b_z_i,
  input  wire logic                   use_z_i,
  input  tds_pkg::tds_flags_t         flags_i,
  output logic [2*CW+1:0]             sum_o,
  output logic [CW-1:0]               absx_o,
  output tds_pkg::tds_flags_t         flags_o
);

  localparam int unsigned SQ_W  = 2 * CW;
  localparam int unsigned SUM_W = 2 * CW + 2;

  logic signed [CW:0] dx, dy, dz;
  logic [CW:0]        nx, ny, nz;
  logic [CW-1:0]      abx_d, aby_d, abz_d;
  logic [CW-1:0]      abx_q, aby_q, abz_q;
  logic [SQ_W-1:0]    sqx_d, sqy_d, sqz_d;
  logic [SQ_W-1:0]    sqx_q, sqy_q, sqz_q;
  logic [CW-1:0]      absx2_q;
  logic [SUM_W-1:0]   sum_d, sum_q;
  logic [CW-1:0]      absx3_q;
  tds_pkg::tds_flags_t f1_q, f2_q, f3_q;

  always_comb begin
    dx = $signed({a_x_i[CW-1], a_x_i}) - $signed({b_x_i[CW-1], b_x_i});
    dy = $signed({a_y_i[CW-1], a_y_i}) - $signed({b_y_i[CW-1], b_y_i});
    dz = $signed({a_z_i[CW-1], a_z_i}) - $signed({b_z_i[CW-1], b_z_i});
    nx = -dx;
    ny = -dy;
    nz = -dz;
    abx_d = dx[CW] ? nx[CW-1:0] : dx[CW-1:0];
    aby_d = dy[CW] ? ny[CW-1:0] : dy[CW-1:0];
    abz_d = use_z_i ? (dz[CW] ? nz[CW-1:0] : dz[CW-1:0]) : '0;
  end

  always_comb begin
    sqx_d = SQ_W'(abx_q) * SQ_W'(abx_q);
    sqy_d = SQ_W'(aby_q) * SQ_W'(aby_q);
    sqz_d = SQ_W'(abz_q) * SQ_W'(abz_q);
    sum_d = SUM_W'(sqx_q) + SUM_W'(sqy_q) + SUM_W'(sqz_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_q <= '0;
      f2_q <= '0;
      f3_q <= '0;
    end else if (en_i) begin
      f1_q <= flags_i;
      f2_q <= f1_q;
      f3_q <= f2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      abx_q   <= abx_d;
      aby_q   <= aby_d;
      abz_q   <= abz_d;
      sqx_q   <= sqx_d;
      sqy_q   <= sqy_d;
      sqz_q   <= sqz_d;
      absx2_q <= abx_q;
      sum_q   <= sum_d;
      absx3_q <= absx2_q;
    end
  end

  assign sum_o   = sum_q;
  assign absx_o  = absx3_q;
  assign flags_o = f3_q;

endmodule
`default_nettype wire

/* hw/rtl/tds_cell.sv */
// One square root cell: settles one root bit and hands the item to the next cell.
`default_nettype none
module tds_cell #(
  parameter int unsigned CW = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic [CW+2:0]          rem_i,
  input  wire logic [CW:0]            root_i,
  input  wire logic [2*CW+1:0]        rad_i,
  input  wire logic [CW-1:0]          absx_i,
  input  tds_pkg::tds_flags_t         flags_i,
  output logic [CW+2:0]               rem_o,
  output logic [CW:0]                 root_o,
  output logic [2*CW+1:0]             rad_o,
  output logic [CW-1:0]               absx_o,
  output tds_pkg::tds_flags_t         flags_o
);

  localparam int unsigned RT_W  = CW + 1;
  localparam int unsigned REM_W = CW + 3;
  localparam int unsigned SUM_W = 2 * CW + 2;

  logic [REM_W-1:0] rem_sh, trial, rem_d, rem_q;
  logic [RT_W-1:0]  root_d, root_q;
  logic [SUM_W-1:0] rad_d, rad_q;
  logic [CW-1:0]    absx_q;
  tds_pkg::tds_flags_t flags_q;

  always_comb begin
    rem_sh = {rem_i[REM_W-3:0], rad_i[SUM_W-1 -: 2]};
    trial  = {1'b0, root_i[RT_W-2:0], 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_i[RT_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_i[RT_W-2:0], 1'b0};
    end
    rad_d = {rad_i[SUM_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (en_i) begin
      flags_q <= flags_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_d;
      absx_q <= absx_i;
    end
  end

  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign rad_o   = rad_q;
  assign absx_o  = absx_q;
  assign flags_o = flags_q;

endmodule
`default_nettype wire

/* hw/rtl/tds_accum.sv */
// Run accumulator with saturation, point counter and result register.
`default_nettype none
module tds_accum #(
  parameter int unsigned CW          = 32,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire logic [CW:0]                         root_i,
  input  wire logic [CW-1:0]                       absx_i,
  input  tds_pkg::tds_flags_t                      flags_i,
  input  wire logic                                mode_i,
  input  wire logic [tds_pkg::DIMS_W-1:0]          dims_i,
  input  wire logic [tds_pkg::LIMIT_W-1:0]         limit_i,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic [tds_pkg::TOTAL_W-1:0]              total_o,
  output logic [tds_pkg::STATUS_W-1:0]             status_o
);

  localparam int unsigned TW    = tds_pkg::TOTAL_W;
  localparam int unsigned CMP_W = (COUNT_WIDTH > tds_pkg::LIMIT_W) ?
                                  COUNT_WIDTH : tds_pkg::LIMIT_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [TW-1:0]          tot_d, tot_q, tot_upd, step_dist;
  logic [TW:0]            sum_w;
  logic [COUNT_WIDTH-1:0] cnt_d, cnt_q;
  logic                   inv_d, inv_q, inv_upd;
  logic                   sat_d, sat_q, sat_upd;
  logic                   multi_dim, take, load;
  logic                   ovalid_d, ovalid_q;
  logic [TW-1:0]          res_total_d, res_total_q;
  logic [tds_pkg::STATUS_W-1:0] res_status_d, res_status_q;

  always_comb begin
    multi_dim = (dims_i >= tds_pkg::DIMS_PLANAR);
    step_dist = multi_dim ? TW'(root_i) : TW'(absx_i);
    sum_w     = {1'b0, tot_q} + {1'b0, step_dist};
    take      = multi_dim || (limit_i == '0) || (CMP_W'(cnt_q) < CMP_W'(limit_i));
    load      = en_i && flags_i.occ && flags_i.last;

    tot_upd = tot_q;
    inv_upd = inv_q;
    sat_upd = sat_q;
    if (!flags_i.pair_ok) begin
      inv_upd = 1'b1;
    end else if (mode_i && take) begin
      if (sum_w > {1'b0, tds_pkg::TOTAL_MAX}) begin
        tot_upd = tds_pkg::TOTAL_MAX;
        sat_upd = 1'b1;
      end else begin
        tot_upd = sum_w[TW-1:0];
      end
    end

    tot_d = tot_q;
    inv_d = inv_q;
    sat_d = sat_q;
    cnt_d = cnt_q;
    if (en_i && flags_i.occ) begin
      if (flags_i.last) begin
        tot_d = '0;
        inv_d = 1'b0;
        sat_d = 1'b0;
        cnt_d = '0;
      end else begin
        tot_d = tot_upd;
        inv_d = inv_upd;
        sat_d = sat_upd;
        cnt_d = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
      end
    end
  end

  always_comb begin
    if (inv_upd) begin
      res_total_d  = '0;
      res_status_d = tds_pkg::STATUS_INVALID;
    end else if (!mode_i) begin
      res_total_d  = '0;
      res_status_d = tds_pkg::STATUS_OK;
    end else begin
      res_total_d  = tot_upd;
      res_status_d = sat_upd ? tds_pkg::STATUS_SATURATED : tds_pkg::STATUS_OK;
    end
    ovalid_d = load ? 1'b1 : (ovalid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q    <= '0;
      cnt_q    <= '0;
      inv_q    <= 1'b0;
      sat_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      tot_q    <= tot_d;
      cnt_q    <= cnt_d;
      inv_q    <= inv_d;
      sat_q    <= sat_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_total_q  <= res_total_d;
      res_status_q <= res_status_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign total_o     = res_total_q;
  assign status_o    = res_status_q;

endmodule
`default_nettype wire
